/* hdl/double_byte_text_to_unicode_unit_defines.svh */
// Assertion macros shared by the checker of the double-byte text decoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef DOUBLE_BYTE_TEXT_TO_UNICODE_UNIT_DEFINES_SVH
`define DOUBLE_BYTE_TEXT_TO_UNICODE_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define DBTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define DBTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dbtu_pkg.sv */
// Shared types and constants of the double-byte text to Unicode decoder.
// Depends on nothing; every other file of the block but the macros header imports it.
package dbtu_pkg;

    localparam int FLAG_TABLE_DEPTH = 256;
    localparam int CODE_TABLE_DEPTH = 65536;
    localparam int FLAG_ADDR_W      = $clog2(FLAG_TABLE_DEPTH);
    localparam int CODE_ADDR_W      = $clog2(CODE_TABLE_DEPTH);

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 16;
    localparam int CODE_W  = 16;

    // Half-width katakana window and its place in the Unicode plane.
    localparam logic [BYTE_W-1:0] KANA_FIRST = 8'hA0;
    localparam logic [BYTE_W-1:0] KANA_END   = 8'hE0;
    localparam logic [CODE_W-1:0] KANA_BASE  = 16'hFF60;

    typedef enum logic [OP_W-1:0] {
        OP_CONVERT    = 2'd0,
        OP_WRITE_FLAG = 2'd1,
        OP_WRITE_CODE = 2'd2
    } dbtu_op_t;

    // Work handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_EMIT   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_WRITE  = 2'd2
    } dbtu_cmd_kind_t;

    typedef struct packed {
        dbtu_cmd_kind_t      kind;
        logic [INDEX_W-1:0]  index;
        logic [CODE_W-1:0]   data;
        logic                last;
    } dbtu_cmd_t;

endpackage

/* hdl/dbtu_in_if.sv */
// Input channel of the decoder: text bytes and table writes.
// Depends on dbtu_pkg for the field widths.
interface dbtu_in_if
    import dbtu_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [BYTE_W-1:0]   text_byte;
    logic [INDEX_W-1:0]  entry_index;
    logic [CODE_W-1:0]   entry_value;

    modport source (output valid, operation, text_byte, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, operation, text_byte, entry_index, entry_value,
                    output ready);
endinterface

/* hdl/dbtu_out_if.sv */
// Output channel of the decoder: decoded Unicode code units.
// Depends on dbtu_pkg for the field widths.
interface dbtu_out_if
    import dbtu_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  unicode_code;
    logic               last;

    modport source (output valid, unicode_code, last, input ready);
    modport sink   (input valid, unicode_code, last, output ready);
endinterface

/* hdl/double_byte_text_to_unicode_unit.sv */
// Double-byte text to Unicode decoder: a front end that classifies text bytes,
// a command queue, and a back end that reads the code table and drives results.
// Every beat on the text channel carries an operation: convert a text byte,
// write one single-byte flag, or write one code table entry. Table writes and
// lead bytes give no result; every other converted byte gives exactly one
// beat on the code channel, in order, with last set on the terminator that a
// zero byte produces.
// Throughput is one beat per cycle in both directions while the receiver keeps
// up. The front end reads the flag table once per byte and settles the lead
// byte in its second stage; the back end reads the code table once per lookup.
// A result passes the second stage, the queue and the result register on its
// way to the code channel, and waits longer when the queue holds earlier work.
// When the receiver stalls, the result register holds its beat, the back end
// stops draining, and the queue of QUEUE_DEPTH commands absorbs the front end's
// output before the text channel drops ready. Code table writes travel through
// the queue too, so lookups always see the code writes that came before them.
// Reset clears the pending lead byte, the queue and the output valid; the two
// tables keep whatever they hold and must be written before they are read.
module double_byte_text_to_unicode_unit
    import dbtu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    dbtu_in_if.sink     text,
    dbtu_out_if.source  code
);

    logic       fq_valid;
    logic       fq_ready;
    dbtu_cmd_t  fq_cmd;
    logic       qb_valid;
    logic       qb_ready;
    dbtu_cmd_t  qb_cmd;

    // Front end: flag lookup, katakana mapping and lead byte tracking.
    dbtu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cmd_valid (fq_valid),
        .cmd       (fq_cmd),
        .cmd_ready (fq_ready)
    );

    // Decouples the two ends so each can stall on its own.
    dbtu_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_cmd   (fq_cmd),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_cmd    (qb_cmd),
        .pop_ready  (qb_ready)
    );

    // Back end: code table writes and double-byte lookups.
    dbtu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd       (qb_cmd),
        .cmd_ready (qb_ready),
        .code      (code)
    );

endmodule

/* hdl/dbtu_front.sv */
// Front end: accepts beats, owns the single-byte flag table and the lead byte.
// Depends on dbtu_pkg and dbtu_in_if; feeds the command queue.
module dbtu_front
    import dbtu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dbtu_in_if.sink    text,
    output logic       cmd_valid,
    output dbtu_cmd_t  cmd,
    input  logic       cmd_ready
);

    logic                flag_mem [FLAG_TABLE_DEPTH];
    logic                flag_rd_reg;

    logic                s1_valid_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    logic [CODE_W-1:0]   s1_value_reg;

    logic                lead_pending_reg;
    logic                lead_pending_next;
    logic [BYTE_W-1:0]   held_lead_reg;
    logic [BYTE_W-1:0]   held_lead_next;

    logic                accept;
    logic                s1_push;
    logic                s1_done;
    logic [BYTE_W-1:0]   kana_offset;
    logic                is_kana;

    assign accept     = text.valid && text.ready;
    assign s1_done    = !s1_push || cmd_ready;
    assign text.ready = !s1_valid_reg || s1_done;
    assign cmd_valid  = s1_valid_reg && s1_push;

    assign kana_offset = s1_byte_reg - KANA_FIRST;
    assign is_kana     = (s1_byte_reg >= KANA_FIRST) && (s1_byte_reg < KANA_END);

    // Flag table: written and read at the accepting edge, read data registered.
    always_ff @(posedge clk)
    begin
        if (accept && text.operation == OP_WRITE_FLAG)
        begin
            flag_mem[text.entry_index[FLAG_ADDR_W-1:0]] <= text.entry_value[0];
        end
        if (accept)
        begin
            flag_rd_reg <= flag_mem[text.text_byte[FLAG_ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= text.operation;
            s1_byte_reg  <= text.text_byte;
            s1_index_reg <= text.entry_index;
            s1_value_reg <= text.entry_value;
        end
    end

    // Classification of the beat held in the second stage.
    always_comb
    begin
        s1_push           = 1'b0;
        cmd               = '{kind: CMD_EMIT, index: s1_index_reg,
                              data: s1_value_reg, last: 1'b0};
        lead_pending_next = lead_pending_reg;
        held_lead_next    = held_lead_reg;
        case (s1_op_reg)
            OP_CONVERT:
            begin
                if (s1_byte_reg == '0)
                begin
                    s1_push           = 1'b1;
                    cmd.data          = '0;
                    cmd.last          = 1'b1;
                    lead_pending_next = 1'b0;
                    held_lead_next    = '0;
                end
                else if (lead_pending_reg)
                begin
                    s1_push           = 1'b1;
                    cmd.kind          = CMD_LOOKUP;
                    cmd.index         = {held_lead_reg, s1_byte_reg};
                    lead_pending_next = 1'b0;
                    held_lead_next    = '0;
                end
                else if (flag_rd_reg)
                begin
                    s1_push  = 1'b1;
                    cmd.data = is_kana ? KANA_BASE + CODE_W'(kana_offset)
                                       : CODE_W'(s1_byte_reg);
                end
                else
                begin
                    lead_pending_next = 1'b1;
                    held_lead_next    = s1_byte_reg;
                end
            end
            OP_WRITE_CODE:
            begin
                s1_push  = 1'b1;
                cmd.kind = CMD_WRITE;
            end
            default:
            begin
                s1_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            lead_pending_reg <= 1'b0;
            held_lead_reg    <= '0;
        end
        else
        begin
            if (text.ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s1_valid_reg && s1_done)
            begin
                lead_pending_reg <= lead_pending_next;
                held_lead_reg    <= held_lead_next;
            end
        end
    end

endmodule

/* hdl/dbtu_cmd_queue.sv */
// Short command queue between the front end and the back end.
// Depends on dbtu_pkg for the command type.
module dbtu_cmd_queue
    import dbtu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    input  dbtu_cmd_t  push_cmd,
    output logic       push_ready,
    output logic       pop_valid,
    output dbtu_cmd_t  pop_cmd,
    input  logic       pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dbtu_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/dbtu_back.sv */
// Back end: owns the code table, carries out lookups and writes, drives results.
// Depends on dbtu_pkg and dbtu_out_if; drained from the command queue.
module dbtu_back
    import dbtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  dbtu_cmd_t   cmd,
    output logic        cmd_ready,
    dbtu_out_if.source  code
);

    logic [CODE_W-1:0]  code_mem [CODE_TABLE_DEPTH];
    logic [CODE_W-1:0]  rd_data_reg;
    logic [CODE_W-1:0]  code_reg;
    logic               last_reg;
    logic               sel_lookup_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               pop;

    assign advance   = !out_valid_reg || code.ready;
    assign cmd_ready = advance;
    assign pop       = cmd_valid && advance;

    assign code.valid        = out_valid_reg;
    assign code.unicode_code = sel_lookup_reg ? rd_data_reg : code_reg;
    assign code.last         = last_reg;

    // Single-port code table with registered read data.
    always_ff @(posedge clk)
    begin
        if (pop && cmd.kind == CMD_WRITE)
        begin
            code_mem[cmd.index[CODE_ADDR_W-1:0]] <= cmd.data;
        end
        else if (pop && cmd.kind == CMD_LOOKUP)
        begin
            rd_data_reg <= code_mem[cmd.index[CODE_ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg <= cmd.data;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            sel_lookup_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg  <= pop && (cmd.kind != CMD_WRITE);
            sel_lookup_reg <= pop && (cmd.kind == CMD_LOOKUP);
        end
    end

endmodule

/* hdl/dbtu_checker.sv */
// Port-level checker of the double-byte text decoder, bound to its top level.
// Depends on dbtu_pkg and the assertion macros header.
`include "double_byte_text_to_unicode_unit_defines.svh"

module dbtu_checker
    import dbtu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [OP_W-1:0]     in_operation,
    input  logic [BYTE_W-1:0]   in_text_byte,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CODE_W-1:0]   out_code,
    input  logic                out_last
);

    logic [7:0]  term_count_reg;
    logic        term_in;
    logic        term_out;

    assign term_in  = in_valid && in_ready && in_operation == OP_CONVERT
                      && in_text_byte == '0;
    assign term_out = out_valid && out_ready && out_last;

    // Terminators taken but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= '0;
        end
        else if (term_in && !term_out)
        begin
            term_count_reg <= term_count_reg + 1'b1;
        end
        else if (term_out && !term_in)
        begin
            term_count_reg <= term_count_reg - 1'b1;
        end
    end

    `DBTU_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result beat withdrawn while stalled")
    `DBTU_ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_valid && !out_ready, $stable(out_code) && $stable(out_last), "result payload changed while stalled")
    `DBTU_ASSERT_IMPLY(a_last_is_zero, clk, rst_n, out_valid && out_last, out_code == '0, "terminator beat carries a nonzero code")
    `DBTU_ASSERT_IMPLY(a_last_has_cause, clk, rst_n, out_valid && out_last, term_count_reg != '0, "terminator beat without a zero text byte")

endmodule

bind double_byte_text_to_unicode_unit dbtu_checker u_dbtu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (text.valid),
    .in_ready     (text.ready),
    .in_operation (text.operation),
    .in_text_byte (text.text_byte),
    .out_valid    (code.valid),
    .out_ready    (code.ready),
    .out_code     (code.unicode_code),
    .out_last     (code.last)
);
